### hw/rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types, constants and helpers for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int WORD_BITS     = 32;
    localparam int QUO_BITS      = WORD_BITS + FRACTION_BITS;
    localparam int WIDE_BITS     = 2 * WORD_BITS + 1;
    localparam int MUL_LAT       = 3;
    localparam int DIV_LAT       = QUO_BITS + 2;
    localparam int IN_BYTES      = (4 + 2 * WORD_BITS + 7) / 8;
    localparam int OUT_BYTES     = (WORD_BITS + 3 + 7) / 8;
    localparam int IN_DATA_BITS  = IN_BYTES * 8;
    localparam int OUT_DATA_BITS = OUT_BYTES * 8;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [3:0] {
        CMD_ADD    = 4'd0,
        CMD_SUB    = 4'd1,
        CMD_MUL    = 4'd2,
        CMD_DIV    = 4'd3,
        CMD_GT     = 4'd4,
        CMD_LT     = 4'd5,
        CMD_GE     = 4'd6,
        CMD_LE     = 4'd7,
        CMD_EQ     = 4'd8,
        CMD_NE     = 4'd9,
        CMD_MIN    = 4'd10,
        CMD_MAX    = 4'd11,
        CMD_INC    = 4'd12,
        CMD_DEC    = 4'd13,
        CMD_TO_INT = 4'd14
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    // operand bundle for the multiplier and divider
    typedef struct packed {
        logic  neg;
        logic  a_neg;
        logic  a_zero;
        t_word mag_a;
        t_word mag_b;
    } t_op;

    typedef struct packed {
        t_word   value;
        t_status status;
    } t_res;

    localparam t_word WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam t_word WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

    // signed word from sign and unsigned magnitude, saturating
    function automatic t_res sat_mag(input logic neg, input logic [WIDE_BITS-1:0] mag);
        logic [WIDE_BITS-1:0] lim;
        t_res                 r;
        lim = neg ? {{(WIDE_BITS-WORD_BITS){1'b0}}, WORD_MIN}
                  : {{(WIDE_BITS-WORD_BITS){1'b0}}, WORD_MAX};
        if (mag > lim) begin
            r.value  = neg ? WORD_MIN : WORD_MAX;
            r.status = ST_OVF;
        end else begin
            r.value  = neg ? (~mag[WORD_BITS-1:0] + t_word'(1)) : mag[WORD_BITS-1:0];
            r.status = ST_OK;
        end
        return r;
    endfunction

endpackage

### hw/rtl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed Q24.8 fixed-point ALU with saturation and rounded multiply/divide.
// ----------------------------------------------------------------------------
// Accepts one item per clock while s_axis_tready is high and returns one
// result per item, in order. All commands see the same latency, set by the
// divider, which resolves one quotient bit per stage over WORD_BITS +
// FRACTION_BITS stages. The whole pipeline advances when the output
// register is empty or being taken; while a valid output is held off by
// the receiver, s_axis_tready is low.
module fixed_point_alu (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // command[3:0], operand_a[35:4], operand_b[67:36], zero pad
    input  logic [fpa_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // result_raw[31:0], compare_true[32], status[34:33], zero pad
    output logic [fpa_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);
    import fpa_pkg::*;

    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // input stage
    logic  r_v0;
    t_cmd  r_cmd0;
    t_word r_a0, r_b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd0 <= t_cmd'(s_axis_tdata[3:0]);
            r_a0   <= s_axis_tdata[4 +: WORD_BITS];
            r_b0   <= s_axis_tdata[4+WORD_BITS +: WORD_BITS];
        end
    end

    // operations computed combinationally from the input stage
    logic               lt, gt, eq;
    logic               add_sub, use_one;
    t_word              rhs;
    logic [WORD_BITS:0] sum;
    t_res               n_simple;
    logic               n_cmp;
    t_op                n_op;

    assign lt = $signed(r_a0) < $signed(r_b0);
    assign gt = $signed(r_b0) < $signed(r_a0);
    assign eq = r_a0 == r_b0;

    assign use_one = (r_cmd0 == CMD_INC) || (r_cmd0 == CMD_DEC);
    assign add_sub = (r_cmd0 == CMD_SUB) || (r_cmd0 == CMD_DEC);
    assign rhs     = use_one ? t_word'(1) : r_b0;
    assign sum     = add_sub ? ({r_a0[WORD_BITS-1], r_a0} - {rhs[WORD_BITS-1], rhs})
                             : ({r_a0[WORD_BITS-1], r_a0} + {rhs[WORD_BITS-1], rhs});

    always_comb begin
        n_simple.value  = '0;
        n_simple.status = ST_OK;
        n_cmp           = 1'b0;
        case (r_cmd0)
            CMD_ADD, CMD_SUB, CMD_INC, CMD_DEC: begin
                if (sum[WORD_BITS] != sum[WORD_BITS-1]) begin
                    n_simple.value  = r_a0[WORD_BITS-1] ? WORD_MIN : WORD_MAX;
                    n_simple.status = ST_OVF;
                end else begin
                    n_simple.value = sum[WORD_BITS-1:0];
                end
            end
            CMD_GT:     n_cmp = gt;
            CMD_LT:     n_cmp = lt;
            CMD_GE:     n_cmp = !lt;
            CMD_LE:     n_cmp = !gt;
            CMD_EQ:     n_cmp = eq;
            CMD_NE:     n_cmp = !eq;
            CMD_MIN:    n_simple.value = lt ? r_a0 : r_b0;
            CMD_MAX:    n_simple.value = gt ? r_a0 : r_b0;
            CMD_TO_INT: n_simple.value = t_word'($signed(r_a0) >>> FRACTION_BITS);
            default:    ;
        endcase
    end

    assign n_op.neg    = r_a0[WORD_BITS-1] ^ r_b0[WORD_BITS-1];
    assign n_op.a_neg  = r_a0[WORD_BITS-1];
    assign n_op.a_zero = r_a0 == '0;
    assign n_op.mag_a  = r_a0[WORD_BITS-1] ? (~r_a0 + t_word'(1)) : r_a0;
    assign n_op.mag_b  = r_b0[WORD_BITS-1] ? (~r_b0 + t_word'(1)) : r_b0;

    logic r_v1;
    t_cmd r_cmd1;
    t_res r_simple1;
    logic r_cmp1;
    t_op  r_op1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd1    <= r_cmd0;
            r_simple1 <= n_simple;
            r_cmp1    <= n_cmp;
            r_op1     <= n_op;
        end
    end

    t_res mul_res, div_res;

    fpa_mul u_mul (
        .i_clk (i_clk),
        .i_en  (en),
        .i_op  (r_op1),
        .o_res (mul_res)
    );

    fpa_div u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_op  (r_op1),
        .o_res (div_res)
    );

    // align everything with the divider output
    localparam int MUL_DLY = DIV_LAT - MUL_LAT;

    logic r_dv     [DIV_LAT];
    t_cmd r_dcmd   [DIV_LAT];
    t_res r_dsim   [DIV_LAT];
    logic r_dcmp   [DIV_LAT];
    t_res r_dmul   [MUL_DLY];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_dv[i] <= 1'b0;
            end
        end else if (en) begin
            r_dv[0] <= r_v1;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dcmd[0] <= r_cmd1;
            r_dsim[0] <= r_simple1;
            r_dcmp[0] <= r_cmp1;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dcmd[i] <= r_dcmd[i-1];
                r_dsim[i] <= r_dsim[i-1];
                r_dcmp[i] <= r_dcmp[i-1];
            end
            r_dmul[0] <= mul_res;
            for (int i = 1; i < MUL_DLY; i++) begin
                r_dmul[i] <= r_dmul[i-1];
            end
        end
    end

    // output register
    t_res n_out;
    logic r_out_valid;
    t_res r_out;
    logic r_out_cmp;

    always_comb begin
        case (r_dcmd[DIV_LAT-1])
            CMD_MUL: n_out = r_dmul[MUL_DLY-1];
            CMD_DIV: n_out = div_res;
            default: n_out = r_dsim[DIV_LAT-1];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_dv[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out     <= n_out;
            r_out_cmp <= r_dcmp[DIV_LAT-1];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_BITS-WORD_BITS-3){1'b0}},
                            r_out.status, r_out_cmp, r_out.value};
endmodule

### hw/rtl/fpa_mul.sv
// ----------------------------------------------------------------------------
// fpa_mul
// Three-stage rounded fixed-point multiplier on magnitudes.
// ----------------------------------------------------------------------------
module fpa_mul (
    input  logic         i_clk,
    input  logic         i_en,
    input  fpa_pkg::t_op i_op,
    output fpa_pkg::t_res o_res
);
    import fpa_pkg::*;

    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int Q_BITS    = WIDE_BITS - FRACTION_BITS;

    logic [PROD_BITS-1:0] r_prod;
    logic                 r_neg1;
    logic [Q_BITS-1:0]    r_q;
    logic                 r_neg2;
    t_res                 r_res;
    logic [WIDE_BITS-1:0] n_sum;

    // round half away from zero on the magnitude
    assign n_sum = {1'b0, r_prod} + (WIDE_BITS'(1) << (FRACTION_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_op.mag_a * i_op.mag_b;
            r_neg1 <= i_op.neg;
            r_q    <= n_sum[WIDE_BITS-1:FRACTION_BITS];
            r_neg2 <= r_neg1;
            r_res  <= sat_mag(r_neg2, {{FRACTION_BITS{1'b0}}, r_q});
        end
    end

    assign o_res = r_res;
endmodule

### hw/rtl/fpa_div.sv
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider, one quotient bit per stage, then rounding
// and saturation stages.
// ----------------------------------------------------------------------------
module fpa_div (
    input  logic          i_clk,
    input  logic          i_en,
    input  fpa_pkg::t_op  i_op,
    output fpa_pkg::t_res o_res
);
    import fpa_pkg::*;

    logic [QUO_BITS-1:0] r_num [QUO_BITS];
    t_word               r_rem [QUO_BITS];
    logic [QUO_BITS-1:0] r_q   [QUO_BITS];
    t_op                 r_op  [QUO_BITS];

    logic [QUO_BITS:0]   r_qr;
    t_word               r_d_last;
    t_op                 r_op_last;
    t_res                r_res;

    genvar k;
    generate
        for (k = 0; k < QUO_BITS; k++) begin : g_stage
            logic [QUO_BITS-1:0] num_in;
            t_word               rem_in;
            logic [QUO_BITS-1:0] q_in;
            t_op                 op_in;
            logic [WORD_BITS:0]  trial;
            logic                ge;

            if (k == 0) begin : g_first
                assign num_in = {i_op.mag_a, {FRACTION_BITS{1'b0}}};
                assign rem_in = '0;
                assign q_in   = '0;
                assign op_in  = i_op;
            end else begin : g_next
                assign num_in = r_num[k-1];
                assign rem_in = r_rem[k-1];
                assign q_in   = r_q[k-1];
                assign op_in  = r_op[k-1];
            end

            assign trial = {rem_in, num_in[QUO_BITS-1]};
            assign ge    = trial >= {1'b0, op_in.mag_b};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[k] <= {num_in[QUO_BITS-2:0], 1'b0};
                    r_rem[k] <= ge ? WORD_BITS'(trial - {1'b0, op_in.mag_b})
                                   : trial[WORD_BITS-1:0];
                    r_q[k]   <= {q_in[QUO_BITS-2:0], ge};
                    r_op[k]  <= op_in;
                end
            end
        end
    endgenerate

    logic [WORD_BITS:0] rem_x;
    logic [WORD_BITS:0] d_x;
    logic               half_up;

    assign rem_x   = {1'b0, r_rem[QUO_BITS-1]};
    assign d_x     = {1'b0, r_op[QUO_BITS-1].mag_b};
    assign half_up = rem_x >= (d_x - rem_x);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qr      <= {1'b0, r_q[QUO_BITS-1]} + (QUO_BITS+1)'(half_up);
            r_d_last  <= r_op[QUO_BITS-1].mag_b;
            r_op_last <= r_op[QUO_BITS-1];
            if (r_d_last == '0) begin
                r_res.status <= ST_DIV0;
                r_res.value  <= r_op_last.a_zero ? '0 :
                                (r_op_last.a_neg ? WORD_MIN : WORD_MAX);
            end else begin
                r_res <= sat_mag(r_op_last.neg,
                                 {{(WIDE_BITS-QUO_BITS-1){1'b0}}, r_qr});
            end
        end
    end

    assign o_res = r_res;
endmodule
